>>> rtl/wdic_pkg.sv
package wdic_pkg;

    localparam int SECRET_BYTES_DEF = 5;
    localparam int CFG_SECRET_BYTES = 5;
    localparam int CFG_SECRET_W     = 8 * CFG_SECRET_BYTES;
    localparam int IV_BYTES         = 3;
    localparam int IV_W             = 8 * IV_BYTES;
    localparam int PERM_DEPTH       = 256;
    localparam int PERM_AW          = $clog2(PERM_DEPTH);

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [2:0]  DELAY_FULL = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_SWAP,
        ST_GEN_OUT
    } t_state;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/wdic_ram.sv
module wdic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/wep_decrypt_icv_check.sv
// WEP frame body decryption with ICV check.
// Input channel (i_in_valid / o_in_stall) takes one encrypted body byte per
// request, ICV bytes included, with first/last markers and the 24-bit IV that
// is used on the first byte. Output channel (o_out_valid / i_out_stall) gives
// one result per input byte: the plaintext byte, and on the last byte the
// frame_end flag with icv_ok and frame_short.
// The user must write the 40-bit secret through i_cfg_we / i_cfg_data only while
// idle; the block itself does not enforce this. One byte at a time: an ordinary
// byte runs the RC4 read-swap-read sequence on the permutation RAM (one write
// port, one read port) in GEN_RD_I, GEN_RD_J, GEN_SWAP and GEN_OUT, where its
// result is registered, before the next request. A first byte adds the identity
// permutation load and the 256-step key schedule on the same RAM.
// Reset clears the secret, the generator indices and the delay line, sets the CRC
// to its initial value; the permutation RAM is undefined until the first frame start.
// A stalled result holds in the output register; the block takes one more
// request, runs it up to the result stage and then waits with o_in_stall high
// until the stalled result leaves.
module wep_decrypt_icv_check #(
    parameter int SECRET_BYTES = wdic_pkg::SECRET_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wdic_pkg::CFG_SECRET_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_first_byte,
    input  logic                              i_last_byte,
    input  logic [wdic_pkg::IV_W-1:0]         i_init_vector,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_plain_byte,
    output logic                              o_frame_end,
    output logic                              o_icv_ok,
    output logic                              o_frame_short
);

    import wdic_pkg::*;

    localparam int KEY_BYTES = IV_BYTES + SECRET_BYTES;
    localparam int KIDX_W    = $clog2(KEY_BYTES);

    t_state                    r_state, n_state;
    logic [CFG_SECRET_W-1:0]   r_secret;
    logic [7:0]                r_key [KEY_BYTES];
    logic [7:0]                n_key [KEY_BYTES];
    logic [KIDX_W-1:0]         r_kidx, n_kidx;
    logic [PERM_AW-1:0]        r_n, n_n;
    logic [PERM_AW-1:0]        r_i, n_i;
    logic [PERM_AW-1:0]        r_j, n_j;
    logic [7:0]                r_si, n_si;
    logic [7:0]                r_sj, n_sj;
    logic [PERM_AW-1:0]        r_idx, n_idx;
    logic [7:0]                r_data, n_data;
    logic                      r_last, n_last;
    logic [31:0]               r_crc, n_crc;
    logic [31:0]               r_delay, n_delay;
    logic [2:0]                r_seen, n_seen;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_plain, n_plain;
    logic                      r_end, n_end;
    logic                      r_ok, n_ok;
    logic                      r_short, n_short;

    logic                      ram_we;
    logic [PERM_AW-1:0]        ram_waddr;
    logic [7:0]                ram_wdata;
    logic [PERM_AW-1:0]        ram_raddr;
    logic [7:0]                ram_rdata;

    logic [7:0]                key_new [KEY_BYTES];
    logic                      in_accept;
    logic                      out_free;
    logic [7:0]                ks_byte;
    logic [7:0]                plain;

    wdic_ram #(
        .WIDTH (8),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // per-frame key: IV bytes, then secret bytes, zero beyond the register
    for (genvar k = 0; k < KEY_BYTES; k++) begin : g_key
        if (k < IV_BYTES) begin : g_iv
            assign key_new[k] = i_init_vector[8*k +: 8];
        end else if (k - IV_BYTES < CFG_SECRET_BYTES) begin : g_sec
            assign key_new[k] = r_secret[8*(k-IV_BYTES) +: 8];
        end else begin : g_zero
            assign key_new[k] = 8'd0;
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        logic [7:0]  j_sum;
        logic [31:0] crc_nx;
        logic [31:0] dly_nx;
        logic [2:0]  seen_nx;
        logic        short_nx;

        n_state     = r_state;
        n_key       = r_key;
        n_kidx      = r_kidx;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_idx       = r_idx;
        n_data      = r_data;
        n_last      = r_last;
        n_crc       = r_crc;
        n_delay     = r_delay;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && i_out_stall;
        n_plain     = r_plain;
        n_end       = r_end;
        n_ok        = r_ok;
        n_short     = r_short;

        ram_we      = 1'b0;
        ram_waddr   = r_n;
        ram_wdata   = r_n;
        ram_raddr   = r_n;

        j_sum       = 8'd0;
        crc_nx      = r_crc;
        dly_nx      = r_delay;
        seen_nx     = r_seen;
        short_nx    = 1'b0;

        // keystream byte, forwarding the swap that may not be in the RAM yet
        if (r_idx == r_j) begin
            ks_byte = r_si;
        end else if (r_idx == r_i) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = ram_rdata;
        end
        plain = r_data ^ ks_byte;

        o_in_stall = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_data = i_data_byte;
                    n_last = i_last_byte;
                    if (i_first_byte) begin
                        n_key   = key_new;
                        n_crc   = CRC_INIT;
                        n_delay = 32'd0;
                        n_seen  = 3'd0;
                        n_n     = '0;
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_GEN_RD_I;
                    end
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_n;
                ram_wdata = r_n;
                n_n       = r_n + 1'b1;
                if (r_n == PERM_AW'(PERM_DEPTH - 1)) begin
                    n_kidx  = '0;
                    n_j     = '0;
                    n_state = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N: begin
                ram_raddr = r_n;
                n_state   = ST_KS_RD_J;
            end
            ST_KS_RD_J: begin
                j_sum     = r_j + ram_rdata + r_key[r_kidx];
                ram_raddr = j_sum;
                n_j       = j_sum;
                n_si      = ram_rdata;
                n_state   = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                ram_we    = 1'b1;
                ram_waddr = r_n;
                ram_wdata = ram_rdata;
                n_state   = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_si;
                n_n       = r_n + 1'b1;
                if (r_kidx == KIDX_W'(KEY_BYTES - 1)) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + 1'b1;
                end
                if (r_n == PERM_AW'(PERM_DEPTH - 1)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_GEN_RD_I;
                end else begin
                    n_state = ST_KS_RD_N;
                end
            end
            ST_GEN_RD_I: begin
                ram_raddr = r_i + 1'b1;
                n_i       = r_i + 1'b1;
                n_state   = ST_GEN_RD_J;
            end
            ST_GEN_RD_J: begin
                j_sum     = r_j + ram_rdata;
                ram_raddr = j_sum;
                n_j       = j_sum;
                n_si      = ram_rdata;
                n_state   = ST_GEN_SWAP;
            end
            ST_GEN_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
                n_sj      = ram_rdata;
                ram_raddr = r_si + ram_rdata;
                n_idx     = r_si + ram_rdata;
                n_state   = ST_GEN_OUT;
            end
            ST_GEN_OUT: begin
                // hold here until the output register is free; the rewrite is harmless
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_si;
                ram_raddr = r_idx;
                if (out_free) begin
                    if (r_seen >= DELAY_FULL) begin
                        crc_nx = crc_byte(r_crc, r_delay[7:0]);
                    end
                    dly_nx = {plain, r_delay[31:8]};
                    if (r_seen < DELAY_FULL) begin
                        seen_nx = r_seen + 3'd1;
                    end
                    short_nx    = (seen_nx < DELAY_FULL);
                    n_crc       = crc_nx;
                    n_delay     = dly_nx;
                    n_seen      = seen_nx;
                    n_out_valid = 1'b1;
                    n_plain     = plain;
                    n_end       = r_last;
                    n_short     = r_last && short_nx;
                    n_ok        = r_last && !short_nx && ((crc_nx ^ CRC_INIT) == dly_nx);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_secret    <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_crc       <= CRC_INIT;
            r_delay     <= 32'd0;
            r_seen      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_secret <= i_cfg_data;
            end
            r_i         <= n_i;
            r_j         <= n_j;
            r_crc       <= n_crc;
            r_delay     <= n_delay;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_kidx  <= n_kidx;
        r_n     <= n_n;
        r_si    <= n_si;
        r_sj    <= n_sj;
        r_idx   <= n_idx;
        r_data  <= n_data;
        r_last  <= n_last;
        r_plain <= n_plain;
        r_end   <= n_end;
        r_ok    <= n_ok;
        r_short <= n_short;
    end

    assign o_out_valid   = r_out_valid;
    assign o_plain_byte  = r_plain;
    assign o_frame_end   = r_end;
    assign o_icv_ok      = r_ok;
    assign o_frame_short = r_short;

endmodule
